// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the circular list store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hdl/cls_pkg.sv -----
// Types and constants of the circular list store.
`timescale 1ns / 1ps

package cls_pkg;

    localparam int unsigned CLS_CAPACITY = 64;
    localparam int unsigned FUNC_W       = 3;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned RCNT_W       = 7;
    localparam logic [RCNT_W-1:0] RCNT_MAX = 7'd127;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INS_FRONT = 3'd0,
        FUNC_INS_BACK  = 3'd1,
        FUNC_LIST      = 3'd2,
        FUNC_REMOVE    = 3'd3,
        FUNC_CLEAR     = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIST,
        S_REMOVE,
        S_RM_FIN
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [VALUE_W-1:0]  item_value;
        logic [RCNT_W-1:0]   removed_count;
        logic                last;
    } cls_result_t;

endpackage

// ----- hdl/cls_req_if.sv -----
// Request channel: operation code and value.
`timescale 1ns / 1ps

interface cls_req_if;
    import cls_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

// ----- hdl/cls_rsp_if.sv -----
// Result channel: status, listed entry, removed count and last marker.
`timescale 1ns / 1ps

interface cls_rsp_if;
    import cls_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  item_value;
    logic [RCNT_W-1:0]          removed_count;
    logic                       last;

    modport source (output valid, output status, output item_value,
                    output removed_count, output last, input ready);
    modport sink (input valid, input status, input item_value,
                  input removed_count, input last, output ready);
endinterface

// ----- hdl/cls_out_fifo.sv -----
// Two-entry result queue in front of the result channel.
`timescale 1ns / 1ps

module cls_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cls_pkg::cls_result_t push_data,
    output logic [1:0]           count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cls_pkg::cls_result_t out_data
);
    import cls_pkg::*;

    cls_result_t slot_reg [2];
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        pop;

    assign pop       = out_valid & out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = cnt_reg;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ----- hdl/circular_list_store_top.sv -----
// Circular list store: ring buffer of 32-bit entries in one synchronous memory.
//
//  channel  dir  payload                                   handshake
//  req      in   func, value                               valid/ready
//  rsp      out  status, item_value, removed_count, last   valid/ready
//
// Insert and clear results pass the pending register, then the output queue; unused
// codes get no result. List and remove read one entry per cycle while the queue has room.
// Remove reads entry i and writes the kept entry back in the following cycle.
// Reset clears head and count; the memory is not swept, so no pass runs after reset.
// A stalled result channel holds the walk once the two-entry output queue and the pending register hold two results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circular_list_store_top #(
    parameter int unsigned CAPACITY = cls_pkg::CLS_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    cls_req_if.sink   req,
    cls_rsp_if.source rsp
);
    import cls_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_A    = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_POS = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] mem_q_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    state_t             state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      kept_reg, kept_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               rm_cmp_valid_reg, rm_cmp_valid_next;
    logic               rm_cmp_last_reg, rm_cmp_last_next;

    logic               pend_valid_reg, pend_valid_next;
    status_t            pend_status_reg, pend_status_next;
    logic               pend_mem_reg, pend_mem_next;
    logic [RCNT_W-1:0]  pend_rcnt_reg, pend_rcnt_next;
    logic               pend_last_reg, pend_last_next;

    logic [1:0]         fifo_cnt;
    logic               pop;
    logic [2:0]         occ;
    logic               space_ok;
    logic               walk_last;
    cls_result_t        push_data;
    cls_result_t        out_data;

    function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= CAP_A)
        begin
            s = s - CAP_A;
        end
        return s[AW-1:0];
    endfunction

    assign pop       = rsp.valid & rsp.ready;
    assign occ       = 3'(fifo_cnt) + 3'(pend_valid_reg);
    // a read issued now pushes next cycle: leave room for it
    assign space_ok  = ((occ - 3'(pop)) <= 3'd1);
    assign walk_last = (CW'(idx_reg) == (count_reg - CW'(1)));

    always_comb
    begin
        logic [CW-1:0] kept_after;
        logic [CW-1:0] removed;

        state_next        = state_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        kept_next         = kept_reg;
        value_next        = value_reg;
        rm_cmp_valid_next = 1'b0;
        rm_cmp_last_next  = 1'b0;
        pend_valid_next   = 1'b0;
        pend_status_next  = ST_OK;
        pend_mem_next     = 1'b0;
        pend_rcnt_next    = '0;
        pend_last_next    = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = '0;
        req.ready         = 1'b0;
        kept_after        = kept_reg;
        removed           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = space_ok;
                if (req.valid && space_ok)
                begin
                    value_next = req.value;
                    case (func_t'(req.func)) inside
                        FUNC_INS_FRONT, FUNC_INS_BACK:
                        begin
                            pend_valid_next = 1'b1;
                            pend_last_next  = 1'b1;
                            if (count_reg == CAP_C)
                            begin
                                pend_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = req.value;
                                count_next = count_reg + CW'(1);
                                if (func_t'(req.func) == FUNC_INS_FRONT)
                                begin
                                    head_next = (head_reg == '0) ? LAST_POS
                                                                 : head_reg - AW'(1);
                                    mem_waddr = head_next;
                                end
                                else
                                begin
                                    mem_waddr = ring(head_reg, count_reg[AW-1:0]);
                                end
                            end
                        end
                        FUNC_LIST, FUNC_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_valid_next  = 1'b1;
                                pend_status_next = ST_EMPTY;
                                pend_last_next   = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                kept_next  = '0;
                                state_next = (func_t'(req.func) == FUNC_LIST) ? S_LIST
                                                                              : S_REMOVE;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            pend_valid_next = 1'b1;
                            pend_last_next  = 1'b1;
                            if (count_reg == '0)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = '0;
                            end
                        end
                        default:
                        begin
                            // unused codes: drop the word
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (space_ok)
                begin
                    mem_re          = 1'b1;
                    mem_raddr       = ring(head_reg, idx_reg);
                    pend_valid_next = 1'b1;
                    pend_mem_next   = 1'b1;
                    pend_last_next  = walk_last;
                    idx_next        = idx_reg + AW'(1);
                    if (walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REMOVE:
            begin
                if (space_ok)
                begin
                    mem_re            = 1'b1;
                    mem_raddr         = ring(head_reg, idx_reg);
                    rm_cmp_valid_next = 1'b1;
                    rm_cmp_last_next  = walk_last;
                    idx_next          = idx_reg + AW'(1);
                    if (walk_last)
                    begin
                        state_next = S_RM_FIN;
                    end
                end
            end
            S_RM_FIN:
            begin
                // wait for the final compare
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // compare stage of remove: keep non-matching entries, packed to the front
        if (rm_cmp_valid_reg)
        begin
            if (mem_q_reg != value_reg)
            begin
                mem_we     = 1'b1;
                mem_waddr  = ring(head_reg, kept_reg[AW-1:0]);
                mem_wdata  = mem_q_reg;
                kept_after = kept_reg + CW'(1);
            end
            kept_next = kept_after;
            if (rm_cmp_last_reg)
            begin
                removed         = count_reg - kept_after;
                count_next      = kept_after;
                state_next      = S_IDLE;
                pend_valid_next = 1'b1;
                pend_last_next  = 1'b1;
                if (removed == '0)
                begin
                    pend_status_next = ST_NOTFOUND;
                end
                else if (32'(removed) > 32'(RCNT_MAX))
                begin
                    pend_rcnt_next = RCNT_MAX;
                end
                else
                begin
                    pend_rcnt_next = RCNT_W'(removed);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            count_reg        <= '0;
            idx_reg          <= '0;
            kept_reg         <= '0;
            rm_cmp_valid_reg <= 1'b0;
            rm_cmp_last_reg  <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            kept_reg         <= kept_next;
            rm_cmp_valid_reg <= rm_cmp_valid_next;
            rm_cmp_last_reg  <= rm_cmp_last_next;
            pend_valid_reg   <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg       <= value_next;
        pend_status_reg <= pend_status_next;
        pend_mem_reg    <= pend_mem_next;
        pend_rcnt_reg   <= pend_rcnt_next;
        pend_last_reg   <= pend_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        push_data.status        = pend_status_reg;
        push_data.item_value    = pend_mem_reg ? mem_q_reg : '0;
        push_data.removed_count = pend_rcnt_reg;
        push_data.last          = pend_last_reg;
    end

    cls_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pend_valid_reg),
        .push_data (push_data),
        .count     (fifo_cnt),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (out_data)
    );

    assign rsp.status        = out_data.status;
    assign rsp.item_value    = out_data.item_value;
    assign rsp.removed_count = out_data.removed_count;
    assign rsp.last          = out_data.last;

    `ASSERT_NEVER(a_queue_overflow, clk, rst_n, pend_valid_reg && (fifo_cnt == 2'd2), "result queue overflow")
    `ASSERT_NEVER(a_count_range, clk, rst_n, 32'(count_reg) > CAPACITY, "entry count above capacity")
    `ASSERT_NEVER(a_rw_collide, clk, rst_n, mem_we && mem_re && (mem_waddr == mem_raddr), "read and write hit one entry")
    `ASSERT_IMPLIES(a_cmp_in_remove, clk, rst_n, rm_cmp_valid_reg, (state_reg == S_REMOVE) || (state_reg == S_RM_FIN), "compare stage outside remove")
endmodule
